// ===== rtl/lgs_pkg.sv =====
// Shared types and constants for the life generation stream block.
// No dependencies; every other file refers to it by scoped names.
package lgs_pkg;

  // Field and register widths fixed by the block's interface
  localparam int SIZE_W    = 9;   // grid_width / grid_height registers
  localparam int ROW_W     = 10;  // input row counter, reaches grid_height + 1
  localparam int COORD_W   = 8;   // col / row result fields
  localparam int CFG_IDX_W = 1;
  localparam int WIN_W     = 9;   // 3x3 neighborhood window

  localparam logic [SIZE_W-1:0] MIN_SIZE = 9'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH  = 1'b0,
    CFG_GRID_HEIGHT = 1'b1
  } cfg_reg_t;

  // Input item kinds
  localparam logic KIND_CELL  = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // B3/S23 rule
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] STAY_COUNT  = 4'd2;

  // Window bit layout: column k holds bits 3k..3k+2 (top, middle, bottom)
  localparam logic [WIN_W-1:0] MASK_TOP   = 9'h049;
  localparam logic [WIN_W-1:0] MASK_LEFT  = 9'h007;
  localparam logic [WIN_W-1:0] MASK_RIGHT = 9'h1C0;
  localparam int               CENTER_IDX = 4;

  // Control for one cell of the line chain
  typedef struct packed {
    logic shift;  // item accepted, advance the chain
    logic load;   // this cell is the insertion point for the current width
  } line_ctrl_t;

  // Control for the window and rule stage
  typedef struct packed {
    logic               accept;
    logic               clear;
    logic               col_zero;
    logic               emit;
    logic               first_col;
    logic               top_row;
    logic               at_right;
    logic               last;
    logic [COORD_W-1:0] out_col;
    logic [COORD_W-1:0] out_row;
  } eval_ctrl_t;

  // One result item
  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic               next_alive;
    logic               changed;
    logic               last_of_frame;
  } result_t;

endpackage

// ===== rtl/lgs_stream_if.sv =====
// Valid/ready channel interfaces for cell items and result items.
// Depends on lgs_pkg for field widths.
interface lgs_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic alive;

  modport source (output valid, kind, alive, input ready);
  modport sink   (input valid, kind, alive, output ready);
endinterface

interface lgs_out_if;
  logic                        valid;
  logic                        ready;
  logic [lgs_pkg::COORD_W-1:0] col;
  logic [lgs_pkg::COORD_W-1:0] row;
  logic                        next_alive;
  logic                        changed;
  logic                        last_of_frame;

  modport source (output valid, col, row, next_alive, changed, last_of_frame, input ready);
  modport sink   (input valid, col, row, next_alive, changed, last_of_frame, output ready);
endinterface

// ===== rtl/lgs_line_cell.sv =====
// One stage of the line chain: holds the {upper, middle} bit pair of one column.
// Depends on lgs_pkg for line_ctrl_t.
module lgs_line_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  lgs_pkg::line_ctrl_t ctrl,
  input  logic [1:0]          ext_d,
  input  logic [1:0]          prev_d,
  output logic [1:0]          q
);

  logic [1:0] q_r;
  logic [1:0] q_nxt;

  // Take the new pair at the insertion point, else the neighbor's pair
  always_comb begin
    q_nxt = q_r;
    if (ctrl.shift) begin
      q_nxt = ctrl.load ? ext_d : prev_d;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else begin
      q_r <= q_nxt;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/lgs_window.sv =====
// 3x3 window register and B3/S23 rule evaluation for one cell per item.
// Depends on lgs_pkg for eval_ctrl_t, result_t, masks and rule counts.
module lgs_window (
  input  logic                clk,
  input  logic                rst_n,
  input  lgs_pkg::eval_ctrl_t ctrl,
  input  logic [2:0]          triple,
  output logic                res_valid,
  output lgs_pkg::result_t    res
);

  logic [lgs_pkg::WIN_W-1:0] win_r;
  logic [lgs_pkg::WIN_W-1:0] win_nxt;
  logic [lgs_pkg::WIN_W-1:0] shifted;
  logic [lgs_pkg::WIN_W-1:0] eval_w;
  logic [3:0]                n_count;
  logic                      old_bit;
  logic                      new_bit;

  // Shift in the newest column
  assign shifted = (win_r >> 3) | {triple, 6'd0};

  // At column zero the finished cell is the last of the earlier row
  always_comb begin
    eval_w = ctrl.col_zero ? (win_r >> 3) : shifted;
    if (ctrl.top_row) begin
      eval_w = eval_w & ~lgs_pkg::MASK_TOP;
    end
    if (ctrl.first_col) begin
      eval_w = eval_w & ~lgs_pkg::MASK_LEFT;
    end
    if (ctrl.at_right) begin
      eval_w = eval_w & ~lgs_pkg::MASK_RIGHT;
    end
  end

  // Count live neighbors
  always_comb begin
    n_count = '0;
    for (int k = 0; k < lgs_pkg::WIN_W; k++) begin
      if (k != lgs_pkg::CENTER_IDX) begin
        n_count = n_count + {3'd0, eval_w[k]};
      end
    end
  end

  assign old_bit = eval_w[lgs_pkg::CENTER_IDX];
  assign new_bit = (n_count == lgs_pkg::BIRTH_COUNT) ||
                   (old_bit && (n_count == lgs_pkg::STAY_COUNT));

  assign res_valid         = ctrl.accept && ctrl.emit;
  assign res.col           = ctrl.out_col;
  assign res.row           = ctrl.out_row;
  assign res.next_alive    = new_bit;
  assign res.changed       = new_bit ^ old_bit;
  assign res.last_of_frame = ctrl.last;

  // Advance on each item, clear on a register write
  always_comb begin
    win_nxt = win_r;
    if (ctrl.clear) begin
      win_nxt = '0;
    end else if (ctrl.accept) begin
      win_nxt = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

endmodule

// ===== rtl/lgs_out_buf.sv =====
// Two-entry output buffer (output register plus skid) for result items.
// Depends on lgs_pkg for result_t and lgs_stream_if for the result channel.
module lgs_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lgs_pkg::result_t push_data,
  output logic             in_ready,
  lgs_out_if.source        out_ch
);

  logic             main_v_r;
  logic             main_v_nxt;
  logic             skid_v_r;
  logic             skid_v_nxt;
  lgs_pkg::result_t main_r;
  lgs_pkg::result_t main_nxt;
  lgs_pkg::result_t skid_r;
  lgs_pkg::result_t skid_nxt;
  logic             pop;

  assign pop      = main_v_r && out_ch.ready;
  assign in_ready = !skid_v_r;

  // Fill the output register first, park in skid when it is held
  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (!main_v_r) begin
      if (push) begin
        main_v_nxt = 1'b1;
        main_nxt   = push_data;
      end
    end else if (!pop) begin
      if (push) begin
        skid_v_nxt = 1'b1;
        skid_nxt   = push_data;
      end
    end else if (skid_v_r) begin
      main_nxt   = skid_r;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      main_nxt = push_data;
    end else begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid         = main_v_r;
  assign out_ch.col           = main_r.col;
  assign out_ch.row           = main_r.row;
  assign out_ch.next_alive    = main_r.next_alive;
  assign out_ch.changed       = main_r.changed;
  assign out_ch.last_of_frame = main_r.last_of_frame;

  // Skid holds an item only behind a held output register
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> main_v_r)
    else $error("skid entry valid with empty output register");

  // A held item and a push never overflow both entries
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_v_r && !pop) |=> skid_v_r && $stable(skid_r))
    else $error("skid entry lost while output held");

endmodule

// ===== rtl/life_generation_stream_top.sv =====
// Top level of the life generation stream: counters, line chain, window, output buffer.
// Depends on lgs_pkg, lgs_stream_if, lgs_line_cell, lgs_window and lgs_out_buf.
//
// Channel  Dir  Handshake        Payload
// in_ch    in   valid / ready    kind, alive
// out_ch   out  valid / ready    col, row, next_alive, changed, last_of_frame
// cfg_*    in   cfg_wr_en        cfg_index (0 width, 1 height), cfg_wdata
//
// One item per cycle while in_ch.ready is high; a cell's result leaves grid_width + 1
// items later, pushed into the registered output buffer by the item that completes it.
// Each item shifts the MAX_SIZE-cell line chain; its delay is exactly grid_width items.
// Reset (synchronous, rst_n low) clears counters, window, chain and buffer.
// in_ch.ready drops only when both output entries hold results; out_ch stalls
// never lose an item.
module life_generation_stream_top #(
  parameter int MAX_SIZE = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lgs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lgs_pkg::SIZE_W-1:0]        cfg_wdata,
  lgs_in_if.sink                            in_ch,
  lgs_out_if.source                         out_ch
);

  localparam int CNT_W      = $clog2(MAX_SIZE + 1);
  localparam int CW         = (CNT_W > lgs_pkg::SIZE_W) ? CNT_W : lgs_pkg::SIZE_W;
  localparam int RESET_SIZE = (MAX_SIZE < 256) ? MAX_SIZE : 256;

  logic [lgs_pkg::SIZE_W-1:0] grid_width_r;
  logic [lgs_pkg::SIZE_W-1:0] grid_width_nxt;
  logic [lgs_pkg::SIZE_W-1:0] grid_height_r;
  logic [lgs_pkg::SIZE_W-1:0] grid_height_nxt;
  logic [lgs_pkg::SIZE_W-1:0] in_col_r;
  logic [lgs_pkg::SIZE_W-1:0] in_col_nxt;
  logic [lgs_pkg::ROW_W-1:0]  in_row_r;
  logic [lgs_pkg::ROW_W-1:0]  in_row_nxt;

  logic                       in_fire;
  logic                       buf_ready;
  logic                       cell_bit;
  logic [1:0]                 tap;
  logic [2:0]                 triple;
  logic [lgs_pkg::ROW_W-1:0]  height_ext;
  logic [lgs_pkg::ROW_W-1:0]  width_ext10;
  logic [lgs_pkg::SIZE_W-1:0] out_col;
  logic [lgs_pkg::SIZE_W-1:0] out_row;
  logic [lgs_pkg::ROW_W-1:0]  col_inc;
  logic [lgs_pkg::SIZE_W-1:0] col_step;
  logic [lgs_pkg::ROW_W-1:0]  row_step;
  logic                       restart;
  logic [CW-1:0]              width_cw;

  lgs_pkg::eval_ctrl_t        ev_ctrl;
  lgs_pkg::result_t           res;
  logic                       res_valid;
  lgs_pkg::line_ctrl_t        line_ctrl [MAX_SIZE];
  logic [1:0]                 chain_q   [MAX_SIZE];

  // Saturate a written size to the supported range
  function automatic logic [lgs_pkg::SIZE_W-1:0] clamp_size(
    input logic [lgs_pkg::SIZE_W-1:0] v
  );
    logic [lgs_pkg::SIZE_W-1:0] r;
    r = v;
    if (v < lgs_pkg::MIN_SIZE) begin
      r = lgs_pkg::MIN_SIZE;
    end else if (int'(v) > MAX_SIZE) begin
      r = lgs_pkg::SIZE_W'(MAX_SIZE);
    end
    return r;
  endfunction

  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = buf_ready;
  assign height_ext  = {1'b0, grid_height_r};
  assign width_ext10 = {1'b0, grid_width_r};
  assign width_cw    = CW'(grid_width_r);

  // Padding rows and flush items count as dead
  assign cell_bit = (in_ch.kind == lgs_pkg::KIND_CELL) && in_ch.alive &&
                    (in_row_r < height_ext);

  // Chain tap gives {upper, middle} of this column; push {middle, new cell}
  assign tap    = chain_q[MAX_SIZE-1];
  assign triple = {cell_bit, tap[0], tap[1]};

  // Line chain
  for (genvar i = 0; i < MAX_SIZE; i++) begin : g_line
    assign line_ctrl[i].shift = in_fire;
    assign line_ctrl[i].load  = (width_cw == CW'(MAX_SIZE - i));
    if (i == 0) begin : g_head
      lgs_line_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (line_ctrl[i]),
        .ext_d  ({tap[0], cell_bit}),
        .prev_d ({tap[0], cell_bit}),
        .q      (chain_q[i])
      );
    end else begin : g_body
      lgs_line_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (line_ctrl[i]),
        .ext_d  ({tap[0], cell_bit}),
        .prev_d (chain_q[i-1]),
        .q      (chain_q[i])
      );
    end
  end

  // Position of the cell finished by this item
  always_comb begin
    if (in_col_r == '0) begin
      out_col = grid_width_r - lgs_pkg::SIZE_W'(1);
      out_row = lgs_pkg::SIZE_W'(in_row_r - lgs_pkg::ROW_W'(2));
    end else begin
      out_col = in_col_r - lgs_pkg::SIZE_W'(1);
      out_row = lgs_pkg::SIZE_W'(in_row_r - lgs_pkg::ROW_W'(1));
    end
  end

  always_comb begin
    ev_ctrl.accept    = in_fire;
    ev_ctrl.clear     = cfg_wr_en;
    ev_ctrl.col_zero  = (in_col_r == '0);
    ev_ctrl.emit      = (in_col_r == '0) ? (in_row_r >= lgs_pkg::ROW_W'(2))
                                         : (in_row_r >= lgs_pkg::ROW_W'(1));
    ev_ctrl.first_col = (out_col == '0);
    ev_ctrl.top_row   = (out_row == '0);
    ev_ctrl.at_right  = ({1'b0, out_col} + lgs_pkg::ROW_W'(1)) == width_ext10;
    ev_ctrl.last      = ev_ctrl.at_right &&
                        (({1'b0, out_row} + lgs_pkg::ROW_W'(1)) == height_ext);
    ev_ctrl.out_col   = out_col[lgs_pkg::COORD_W-1:0];
    ev_ctrl.out_row   = out_row[lgs_pkg::COORD_W-1:0];
  end

  lgs_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ev_ctrl),
    .triple    (triple),
    .res_valid (res_valid),
    .res       (res)
  );

  lgs_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .in_ready  (buf_ready),
    .out_ch    (out_ch)
  );

  // Advance raster position; restart after the last padding position
  always_comb begin
    col_inc = {1'b0, in_col_r} + lgs_pkg::ROW_W'(1);
    if (col_inc >= width_ext10) begin
      col_step = '0;
      row_step = in_row_r + lgs_pkg::ROW_W'(1);
    end else begin
      col_step = col_inc[lgs_pkg::SIZE_W-1:0];
      row_step = in_row_r;
    end
    restart = (row_step > height_ext + lgs_pkg::ROW_W'(1)) ||
              ((row_step == height_ext + lgs_pkg::ROW_W'(1)) && (col_step != '0));
  end

  // Configuration writes and counter updates
  always_comb begin
    grid_width_nxt  = grid_width_r;
    grid_height_nxt = grid_height_r;
    in_col_nxt      = in_col_r;
    in_row_nxt      = in_row_r;
    if (cfg_wr_en) begin
      if (cfg_index == lgs_pkg::CFG_GRID_WIDTH) begin
        grid_width_nxt = clamp_size(cfg_wdata);
      end else begin
        grid_height_nxt = clamp_size(cfg_wdata);
      end
      in_col_nxt = '0;
      in_row_nxt = '0;
    end else if (in_fire) begin
      if (restart) begin
        in_col_nxt = '0;
        in_row_nxt = '0;
      end else begin
        in_col_nxt = col_step;
        in_row_nxt = row_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_width_r  <= lgs_pkg::SIZE_W'(RESET_SIZE);
      grid_height_r <= lgs_pkg::SIZE_W'(RESET_SIZE);
      in_col_r      <= '0;
      in_row_r      <= '0;
    end else begin
      grid_width_r  <= grid_width_nxt;
      grid_height_r <= grid_height_nxt;
      in_col_r      <= in_col_nxt;
      in_row_r      <= in_row_nxt;
    end
  end

  // Column stays inside the row
  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    in_col_r < grid_width_r)
    else $error("input column beyond grid width");

  // Row never passes the padding row
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (in_row_r < height_ext + lgs_pkg::ROW_W'(1)) ||
    ((in_row_r == height_ext + lgs_pkg::ROW_W'(1)) && (in_col_r == '0)))
    else $error("input position beyond frame");

  // A register write restarts the frame
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (in_col_r == '0) && (in_row_r == '0))
    else $error("frame not restarted after register write");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for life_generation_stream_top: streams cell frames
// in, predicts each next-generation result and checks it. Needs lgs_pkg,
// the lgs_in_if / lgs_out_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_CELLS    = 256;
  localparam int IDLE_PCT     = 38;
  localparam int TOTAL_ITEMS  = 500;
  localparam int FRAME_CAP    = 96;
  localparam int DRAIN_CYCLES = 8;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_wr_en;
  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lgs_pkg::SIZE_W-1:0]    cfg_wdata;

  lgs_in_if  in_ch ();
  lgs_out_if out_ch ();

  bit          no_idle;
  int unsigned items_sent;

  life_generation_stream_top #(.MAX_SIZE(MAX_CELLS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Saturate a written size into the legal range
  function automatic int unsigned clamp_size(logic [lgs_pkg::SIZE_W-1:0] v);
    if (v < 3) return 3;
    if (v > MAX_CELLS) return MAX_CELLS;
    return int'(v);
  endfunction

  // Next-generation predictor and queue of pending results
  class generation_tracker;
    int unsigned               grid_w;
    int unsigned               grid_h;
    bit                        upper_row [MAX_CELLS];
    bit                        middle_row [MAX_CELLS];
    logic [lgs_pkg::WIN_W-1:0] nbhd;
    int unsigned               in_col, in_row, out_col, out_row;
    lgs_pkg::result_t          next_gen_q [$];
    int unsigned               mismatches;

    function new();
      grid_w = MAX_CELLS;
      grid_h = MAX_CELLS;
      foreach (upper_row[i]) begin
        upper_row[i]  = 1'b0;
        middle_row[i] = 1'b0;
      end
      mismatches = 0;
      restart();
    endfunction

    // Clear counters and window; line stores are kept
    function void restart();
      nbhd    = '0;
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
      out_row = 0;
    endfunction

    function void write_reg(logic [lgs_pkg::CFG_IDX_W-1:0] idx,
                            logic [lgs_pkg::SIZE_W-1:0] v);
      if (idx == lgs_pkg::CFG_GRID_WIDTH) grid_w = clamp_size(v);
      else grid_h = clamp_size(v);
      restart();
    endfunction

    // Apply B3/S23 to a window centered on (out_col, out_row), then advance
    function lgs_pkg::result_t rule_at(logic [lgs_pkg::WIN_W-1:0] w);
      lgs_pkg::result_t          r;
      logic [lgs_pkg::WIN_W-1:0] nb;
      int unsigned               n;
      bit                        old, nxt;
      nb = w;
      if (out_row == 0) nb &= ~lgs_pkg::MASK_TOP;
      if (out_col == 0) nb &= ~lgs_pkg::MASK_LEFT;
      if (out_col + 1 >= grid_w) nb &= ~lgs_pkg::MASK_RIGHT;
      old = nb[lgs_pkg::CENTER_IDX];
      n   = $countones(nb) - old;
      nxt = (n == lgs_pkg::BIRTH_COUNT) || (old && n == lgs_pkg::STAY_COUNT);
      r.col           = 8'(out_col);
      r.row           = 8'(out_row);
      r.next_alive    = nxt;
      r.changed       = nxt ^ old;
      r.last_of_frame = (out_col + 1 == grid_w) && (out_row + 1 == grid_h);
      out_col++;
      if (out_col >= grid_w) begin
        out_col = 0;
        out_row++;
        if (out_row >= grid_h) out_row = 0;
      end
      return r;
    endfunction

    // Note one accepted input item
    function void note_item(logic kind, logic alive);
      bit         live, up, mid;
      logic [2:0] column;
      live = (kind == lgs_pkg::KIND_CELL) && alive && (in_row < grid_h);
      up   = upper_row[in_col];
      mid  = middle_row[in_col];
      upper_row[in_col]  = mid;
      middle_row[in_col] = live;
      column = {live, mid, up};
      if (in_col == 0) begin
        // right column of the finished row lies outside the grid
        if (in_row >= 2) next_gen_q.push_back(rule_at({3'b000, nbhd[8:3]}));
        nbhd = {column, nbhd[8:3]};
      end else begin
        nbhd = {column, nbhd[8:3]};
        if (in_row >= 1) next_gen_q.push_back(rule_at(nbhd));
      end
      in_col++;
      if (in_col >= grid_w) begin
        in_col = 0;
        in_row++;
      end
      if (in_row > grid_h + 1 || (in_row == grid_h + 1 && in_col >= 1)) begin
        in_col  = 0;
        in_row  = 0;
        out_col = 0;
        out_row = 0;
      end
    endfunction

    function void flag_error(string msg);
      mismatches++;
      if (mismatches <= 10) $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Compare one accepted result with the oldest prediction
    function void check_result(lgs_pkg::result_t got);
      lgs_pkg::result_t exp;
      if (next_gen_q.size() == 0) begin
        flag_error($sformatf("unexpected result col %0d row %0d", got.col, got.row));
        return;
      end
      exp = next_gen_q.pop_front();
      if (got.col !== exp.col || got.row !== exp.row ||
          got.next_alive !== exp.next_alive || got.changed !== exp.changed ||
          got.last_of_frame !== exp.last_of_frame)
        flag_error($sformatf({"expected col %0d row %0d next %0b chg %0b last %0b, ",
                              "got col %0d row %0d next %0b chg %0b last %0b"},
                             exp.col, exp.row, exp.next_alive, exp.changed,
                             exp.last_of_frame, got.col, got.row, got.next_alive,
                             got.changed, got.last_of_frame));
    endfunction
  endclass

  generation_tracker tracker = new();

  // Clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard limit on run length
  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

  // Result side: hold off in reset, then stall at random unless idling is off
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
  end

  // Observe config writes, accepted items and accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_wr_en) tracker.write_reg(cfg_index, cfg_wdata);
      if (in_ch.valid && in_ch.ready) tracker.note_item(in_ch.kind, in_ch.alive);
      if (out_ch.valid && out_ch.ready) begin
        lgs_pkg::result_t got;
        got.col           = out_ch.col;
        got.row           = out_ch.row;
        got.next_alive    = out_ch.next_alive;
        got.changed       = out_ch.changed;
        got.last_of_frame = out_ch.last_of_frame;
        tracker.check_result(got);
      end
    end
  end

  // Offer one item, with a random gap first; return at the accepting edge
  task automatic send_item(logic k, logic a);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.alive <= a;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait for every predicted result, then let the pipe empty
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (tracker.next_gen_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(lgs_pkg::cfg_reg_t idx, logic [lgs_pkg::SIZE_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Stream len items of a w x h frame; noisy frames mix kinds at random
  task automatic send_frame(int unsigned w, int unsigned h, int unsigned density,
                            bit noisy, int unsigned len);
    logic k, a;
    for (int unsigned i = 0; i < len; i++) begin
      if (i < w * h) begin
        k = (noisy && $urandom_range(7) == 0) ? lgs_pkg::KIND_FLUSH : lgs_pkg::KIND_CELL;
        a = ($urandom_range(99) < density);
      end else begin
        k = noisy ? 1'($urandom_range(1)) : lgs_pkg::KIND_FLUSH;
        a = 1'($urandom_range(1));
      end
      send_item(k, a);
    end
  endtask

  // Directed 3x3 frames as {kind, alive}: a flush inside the grid,
  // live cells in the padding, then a fully live grid
  logic [1:0] directed_items [26] = '{
    2'b01, 2'b01, 2'b01,  2'b00, 2'b11, 2'b01,  2'b01, 2'b01, 2'b01,
    2'b01, 2'b11, 2'b01, 2'b10,
    2'b01, 2'b01, 2'b01,  2'b01, 2'b01, 2'b01,  2'b01, 2'b01, 2'b01,
    2'b11, 2'b10, 2'b11, 2'b10
  };

  initial begin
    int unsigned cur_w, cur_h, full, len, nframes;
    int unsigned pick, style;
    logic [lgs_pkg::SIZE_W-1:0] wv, hv;

    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_index    = lgs_pkg::CFG_GRID_WIDTH;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = lgs_pkg::KIND_CELL;
    in_ch.alive  = 1'b0;
    no_idle      = 1'b0;
    items_sent   = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size, no idling on either side: head of a 256 x 256 frame
    no_idle = 1'b1;
    send_frame(MAX_CELLS, MAX_CELLS, 50, 1'b0, MAX_CELLS + 8);
    settle();
    no_idle = 1'b0;

    // Directed: sizes below range saturate to 3
    write_reg(lgs_pkg::CFG_GRID_WIDTH, 9'd0);
    write_reg(lgs_pkg::CFG_GRID_HEIGHT, 9'd2);
    foreach (directed_items[i]) send_item(directed_items[i][1], directed_items[i][0]);
    settle();
    cur_w = 3;
    cur_h = 3;

    // Random phases: new sizes, then a few frames
    while (items_sent < TOTAL_ITEMS) begin
      pick = $urandom_range(19);
      if (pick == 0) begin
        wv = lgs_pkg::SIZE_W'($urandom_range(511));
        hv = lgs_pkg::SIZE_W'($urandom_range(5));
      end else if (pick == 1) begin
        wv = lgs_pkg::SIZE_W'($urandom_range(4));
        hv = lgs_pkg::SIZE_W'($urandom_range(511));
      end else begin
        wv = lgs_pkg::SIZE_W'($urandom_range(3, 8));
        hv = lgs_pkg::SIZE_W'($urandom_range(3, 8));
      end
      pick = $urandom_range(3);
      if (pick != 1) begin
        write_reg(lgs_pkg::CFG_GRID_WIDTH, wv);
        cur_w = clamp_size(wv);
      end
      if (pick != 0) begin
        write_reg(lgs_pkg::CFG_GRID_HEIGHT, hv);
        cur_h = clamp_size(hv);
      end
      full    = cur_w * cur_h + cur_w + 1;
      nframes = $urandom_range(1, 3);
      for (int f = 0; f < nframes; f++) begin
        style = $urandom_range(9);
        pick  = $urandom_range(4);
        if (style == 9 || full > FRAME_CAP) begin
          // truncated frame; the next register write restarts it
          len = (full > FRAME_CAP) ? FRAME_CAP : $urandom_range(1, full - 1);
          send_frame(cur_w, cur_h, $urandom_range(100), 1'b0, len);
          break;
        end
        send_frame(cur_w, cur_h, (pick == 0) ? 0 : (pick == 1) ? 100 : $urandom_range(100),
                   style >= 7, full);
      end
      settle();
    end

    if (tracker.mismatches == 0 && tracker.next_gen_q.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
